// ===== rtl/swept_tone_oscillator_defines.svh =====
// Assertion helpers used by the checker.
`ifndef SWEPT_TONE_OSCILLATOR_DEFINES_SVH
`define SWEPT_TONE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define STO_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sto check failed");

// Next-cycle implication, off during reset.
`define STO_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sto check failed");

// Signal is low in the cycle after reset is held.
`define STO_CHECK_RESET(label, sig) \
  label: assert property (@(posedge clk) !rst_n |=> !(sig)) \
    else $error("sto reset check failed");

`endif

// ===== rtl/sto_pkg.sv =====
package sto_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 8;
  localparam int INC_BITS      = 31;
  localparam int STEP_BITS     = 24;
  localparam int SEED_BITS     = 16;
  localparam int WAVE_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 31;
  localparam int IN_DATA_BITS  = 8;

  localparam logic [SEED_BITS-1:0] DEFAULT_SEED = 16'hACE1;
  localparam logic [SEED_BITS-1:0] LFSR_TAPS    = 16'hB400;
  localparam logic [INC_BITS-1:0]  INC_MAX      = '1;

  typedef enum logic [WAVE_BITS-1:0] {
    WAVE_MUTE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_RAMP     = 3'd2,
    WAVE_PULSE    = 3'd3,
    WAVE_LFSR     = 3'd4
  } wave_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WAVE      = 2'd0,
    CFG_START_INC = 2'd1,
    CFG_INC_STEP  = 2'd2,
    CFG_SEED      = 2'd3
  } cfg_idx_t;

  // Sample that bypasses scaling (noise).
  typedef struct packed {
    logic                   raw;
    logic [SAMPLE_BITS-1:0] value;
  } raw_sample_t;

endpackage

// ===== rtl/swept_tone_oscillator.sv =====
// Latency: three register stages; the sample word for an accepted input word is
// registered by the phase, wave and scale stages in turn, then shown on out_tvalid.
// Throughput: one word per cycle while out_tready is high; phase, increment and
// LFSR update on accept; wave shaping and scaling follow in two registered stages.
// in_tready stays high while out_tready is high; a full pipeline stalls input.
// Reset (rst_n low, synchronous): phase and increment zero, LFSR and seed 0xACE1,
// registers at their defaults, pipeline empty.
module swept_tone_oscillator #(
  parameter int PHASE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sto_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [0] restart
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sto_pkg::SAMPLE_BITS-1:0]   out_tdata,  // [15:0] sample_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sto_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sto_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  sto_pkg::wave_t                wave_r;
  logic [sto_pkg::INC_BITS-1:0]  start_inc_r;
  logic [sto_pkg::STEP_BITS-1:0] inc_step_r;
  logic [sto_pkg::SEED_BITS-1:0] seed_r;

  logic                          ph_valid, ph_ready;
  logic [PHASE_BITS-1:0]         ph_phase;
  sto_pkg::wave_t                ph_wave;
  logic [sto_pkg::SEED_BITS-1:0] ph_noise;

  logic                          wv_valid, wv_ready;
  logic                          wv_neg;
  logic [PHASE_BITS-1:0]         wv_mag;
  sto_pkg::raw_sample_t          wv_raw;

  assign cfg_ready = 1'b1;

  // zero seed would lock the LFSR
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= sto_pkg::WAVE_MUTE;
      start_inc_r <= '0;
      inc_step_r  <= '0;
      seed_r      <= sto_pkg::DEFAULT_SEED;
    end else if (cfg_valid && cfg_ready) begin
      case (sto_pkg::cfg_idx_t'(cfg_index))
        sto_pkg::CFG_WAVE:
          wave_r <= sto_pkg::wave_t'(cfg_data[sto_pkg::WAVE_BITS-1:0]);
        sto_pkg::CFG_START_INC:
          start_inc_r <= cfg_data[sto_pkg::INC_BITS-1:0];
        sto_pkg::CFG_INC_STEP:
          inc_step_r <= cfg_data[sto_pkg::STEP_BITS-1:0];
        sto_pkg::CFG_SEED:
          seed_r <= (cfg_data[sto_pkg::SEED_BITS-1:0] == '0) ? sto_pkg::DEFAULT_SEED
                                                             : cfg_data[sto_pkg::SEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  sto_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .restart   (in_tdata[0]),
    .wave      (wave_r),
    .start_inc (start_inc_r),
    .inc_step  (inc_step_r),
    .seed      (seed_r),
    .m_valid   (ph_valid),
    .m_ready   (ph_ready),
    .m_phase   (ph_phase),
    .m_wave    (ph_wave),
    .m_noise   (ph_noise)
  );

  sto_wave #(.PHASE_BITS(PHASE_BITS)) u_wave (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (ph_valid),
    .s_ready (ph_ready),
    .phase   (ph_phase),
    .wave    (ph_wave),
    .noise   (ph_noise),
    .m_valid (wv_valid),
    .m_ready (wv_ready),
    .m_neg   (wv_neg),
    .m_mag   (wv_mag),
    .m_raw   (wv_raw)
  );

  sto_scale #(.PHASE_BITS(PHASE_BITS)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (wv_valid),
    .s_ready (wv_ready),
    .neg     (wv_neg),
    .mag     (wv_mag),
    .raw     (wv_raw),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

endmodule

// ===== rtl/sto_phase.sv =====
module sto_phase #(
  parameter int PHASE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  input  sto_pkg::wave_t                      wave,
  input  logic [sto_pkg::INC_BITS-1:0]        start_inc,
  input  logic [sto_pkg::STEP_BITS-1:0]       inc_step,
  input  logic [sto_pkg::SEED_BITS-1:0]       seed,
  output logic                                m_valid,
  input  logic                                m_ready,
  output logic [PHASE_BITS-1:0]               m_phase,
  output sto_pkg::wave_t                      m_wave,
  output logic [sto_pkg::SEED_BITS-1:0]       m_noise
);

  localparam int INT_BITS = sto_pkg::INC_BITS - sto_pkg::FRAC_BITS;
  localparam int SUM_BITS = (PHASE_BITS > INT_BITS) ? PHASE_BITS : INT_BITS;
  localparam int EXT_BITS = sto_pkg::INC_BITS + 2 - sto_pkg::STEP_BITS;

  logic [PHASE_BITS-1:0]         phase_r, phase_nxt, phase_cur;
  logic [sto_pkg::INC_BITS-1:0]  inc_r, inc_nxt, inc_cur;
  logic [sto_pkg::SEED_BITS-1:0] lfsr_r, lfsr_nxt, lfsr_cur, lfsr_adv;
  logic [sto_pkg::INC_BITS+1:0]  inc_sum;
  logic [SUM_BITS-1:0]           phase_sum;
  logic                          valid_r;
  logic [PHASE_BITS-1:0]         s_phase_r;
  sto_pkg::wave_t                s_wave_r;
  logic [sto_pkg::SEED_BITS-1:0] s_noise_r;
  logic                          accept;

  assign in_ready = !valid_r || m_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_cur = restart ? '0 : phase_r;
    inc_cur   = restart ? start_inc : inc_r;
    lfsr_cur  = restart ? seed : lfsr_r;
    lfsr_adv  = {1'b0, lfsr_cur[sto_pkg::SEED_BITS-1:1]} ^
                (lfsr_cur[0] ? sto_pkg::LFSR_TAPS : '0);
    lfsr_nxt  = (wave == sto_pkg::WAVE_LFSR) ? lfsr_adv : lfsr_cur;
    phase_sum = SUM_BITS'(phase_cur) +
                SUM_BITS'(inc_cur[sto_pkg::INC_BITS-1:sto_pkg::FRAC_BITS]);
    phase_nxt = phase_sum[PHASE_BITS-1:0];
    inc_sum   = {2'b00, inc_cur} + {{EXT_BITS{inc_step[sto_pkg::STEP_BITS-1]}}, inc_step};
    if (inc_sum[sto_pkg::INC_BITS+1]) begin
      inc_nxt = '0;
    end else if (inc_sum[sto_pkg::INC_BITS]) begin
      inc_nxt = sto_pkg::INC_MAX;
    end else begin
      inc_nxt = inc_sum[sto_pkg::INC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      inc_r   <= '0;
      lfsr_r  <= sto_pkg::DEFAULT_SEED;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        inc_r   <= inc_nxt;
        lfsr_r  <= lfsr_nxt;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_phase_r <= phase_cur;
      s_wave_r  <= wave;
      s_noise_r <= lfsr_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_phase = s_phase_r;
  assign m_wave  = s_wave_r;
  assign m_noise = s_noise_r;

endmodule

// ===== rtl/sto_wave.sv =====
module sto_wave #(
  parameter int PHASE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [PHASE_BITS-1:0]         phase,
  input  sto_pkg::wave_t                wave,
  input  logic [sto_pkg::SEED_BITS-1:0] noise,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_neg,
  output logic [PHASE_BITS-1:0]         m_mag,
  output sto_pkg::raw_sample_t          m_raw
);

  localparam logic [PHASE_BITS:0]   TURN     = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic [PHASE_BITS-1:0] QUARTER  = {2'b01, {(PHASE_BITS-2){1'b0}}};
  localparam logic [PHASE_BITS+1:0] HALF     = {3'b001, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS+1:0] HALF_NEG = ~HALF + 1'b1;

  logic [PHASE_BITS-1:0] g;
  logic [PHASE_BITS:0]   tg, d;
  logic [PHASE_BITS+1:0] num, num_abs;
  logic                  neg;
  sto_pkg::raw_sample_t  raw;
  logic                  valid_r;
  logic                  neg_r;
  logic [PHASE_BITS-1:0] mag_r;
  sto_pkg::raw_sample_t  raw_r;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    g  = phase + QUARTER;
    tg = TURN - {1'b0, g};
    d  = ({1'b0, g} <= tg) ? {1'b0, g} : tg;
    case (wave)
      sto_pkg::WAVE_TRIANGLE: num = {d, 1'b0} - HALF;
      sto_pkg::WAVE_RAMP:     num = HALF - {2'b00, phase};
      sto_pkg::WAVE_PULSE:    num = phase[PHASE_BITS-1] ? HALF_NEG : HALF;
      default:                num = '0;
    endcase
    neg       = num[PHASE_BITS+1];
    num_abs   = neg ? ('0 - num) : num;
    raw.raw   = (wave == sto_pkg::WAVE_LFSR);
    raw.value = noise;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      neg_r <= neg;
      mag_r <= num_abs[PHASE_BITS-1:0];
      raw_r <= raw;
    end
  end

  assign m_valid = valid_r;
  assign m_neg   = neg_r;
  assign m_mag   = mag_r;
  assign m_raw   = raw_r;

endmodule

// ===== rtl/sto_scale.sv =====
module sto_scale #(
  parameter int PHASE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  logic                            neg,
  input  logic [PHASE_BITS-1:0]           mag,
  input  sto_pkg::raw_sample_t            raw,
  output logic                            m_valid,
  input  logic                            m_ready,
  output logic [sto_pkg::SAMPLE_BITS-1:0] m_data
);

  localparam int PROD_BITS = PHASE_BITS + sto_pkg::SAMPLE_BITS;

  logic [PROD_BITS-1:0]            prod;
  logic [sto_pkg::SAMPLE_BITS-1:0] q, sample;
  logic                            valid_r;
  logic [sto_pkg::SAMPLE_BITS-1:0] data_r;

  assign s_ready = !valid_r || m_ready;

  // mag * (2^SAMPLE_BITS - 1) >> PHASE_BITS
  always_comb begin
    prod   = {mag, {sto_pkg::SAMPLE_BITS{1'b0}}} - PROD_BITS'(mag);
    q      = prod[PROD_BITS-1:PHASE_BITS];
    sample = raw.raw ? raw.value : (neg ? ('0 - q) : q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= sample;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

// ===== rtl/sto_checker.sv =====
`include "swept_tone_oscillator_defines.svh"

module sto_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sto_pkg::SAMPLE_BITS-1:0] out_tdata
);

  `STO_CHECK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `STO_CHECK_NOW(a_no_bubble, out_tready, in_tready)
  `STO_CHECK_NOW(a_stall_full, !in_tready, out_tvalid && !out_tready)
  `STO_CHECK_RESET(a_reset_empty, out_tvalid)

endmodule

bind swept_tone_oscillator sto_checker u_sto_checker (.*);
